// ===== src/ipx_pkg.sv =====
// Shared types, constants and helpers for the indexed pixel palette expander.
package ipx_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int MAX_WIDTH       = 2048;
    localparam int MAX_HEIGHT      = 2048;
    localparam int STRIDE_LIMIT    = 2048;

    localparam int PAL_AW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CLAMP_W   = CFG_W + 1;
    localparam int CNT_W     = 12;
    localparam int BYTE_W    = $clog2(STRIDE_LIMIT);
    localparam int POS_W     = 11;
    localparam int PIXN_W    = 4;
    localparam int COLOUR_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORMAT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_STRIDE = 2'd3
    } t_cfg_reg;

    localparam logic [2:0] FMT_1BPP = 3'd0;
    localparam logic [2:0] FMT_2BPP = 3'd1;
    localparam logic [2:0] FMT_4BPP = 3'd2;
    localparam logic [2:0] FMT_8BPP = 3'd3;

    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_PIXEL   = 1'b1;

    localparam logic [7:0] MASK_2BPP = 8'h03;
    localparam logic [7:0] MASK_4BPP = 8'h0F;

    typedef struct packed {
        logic                mode;
        logic [7:0]          palette_index;
        logic [COLOUR_W-1:0] palette_colour;
        logic [7:0]          raw_byte;
        logic                frame_start;
    } t_in;

    typedef struct packed {
        logic [COLOUR_W-1:0] pixel_argb;
        logic [POS_W-1:0]    pixel_x;
        logic [POS_W-1:0]    pixel_y;
        logic                last_of_byte;
    } t_out;

    // One byte's worth of work handed to the unpacker
    typedef struct packed {
        logic [7:0]        raw_byte;
        logic [1:0]        fmt;
        logic [PIXN_W-1:0] count;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
    } t_job;

    typedef struct packed {
        logic                en;
        logic [PAL_AW-1:0]   addr;
        logic [COLOUR_W-1:0] data;
    } t_pal_wr;

    function automatic logic [7:0] pix_mask(input logic [1:0] fmt);
        logic [7:0] m;
        unique case (fmt)
            2'd0:    m = 8'h01;
            2'd1:    m = MASK_2BPP;
            2'd2:    m = MASK_4BPP;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

    function automatic logic [PIXN_W-1:0] pix_per_byte(input logic [1:0] fmt);
        logic [PIXN_W-1:0] n;
        unique case (fmt)
            2'd0:    n = PIXN_W'(8);
            2'd1:    n = PIXN_W'(4);
            2'd2:    n = PIXN_W'(2);
            default: n = PIXN_W'(1);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] pix_next(input logic [7:0] b, input logic [1:0] fmt);
        logic [7:0] r;
        unique case (fmt)
            2'd0:    r = b >> 1;
            2'd1:    r = b >> 2;
            2'd2:    r = b >> 4;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== src/ipx_ram.sv =====
// Generic single-write, single-read RAM with registered, read-first output.
module ipx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ipx_ctrl.sv =====
// Configuration registers, row/column position tracking and transaction intake.
module ipx_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ipx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ipx_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ipx_pkg::t_in                i_in_data,
    input  logic                        i_free,
    output logic                        o_load,
    output ipx_pkg::t_job               o_job,
    output ipx_pkg::t_pal_wr            o_pal_wr
);
    import ipx_pkg::*;

    logic [2:0]        r_format;
    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic [CFG_W-1:0]  r_stride;

    logic [BYTE_W-1:0] r_byte_in_row, n_byte_in_row;
    logic [CNT_W-1:0]  r_pix_in_row,  n_pix_in_row;
    logic [CNT_W-1:0]  r_row,         n_row;

    logic               w_acc;
    logic [CLAMP_W-1:0] w_width, w_height, w_stride;
    logic [BYTE_W-1:0]  w_byte_c;
    logic [CNT_W-1:0]   w_pix_c, w_row_c;
    logic [CNT_W:0]     w_byte_inc;
    logic [CLAMP_W-1:0] w_room;
    logic [PIXN_W-1:0]  w_per_byte, w_count;
    logic               w_fmt_ok, w_active, w_is_pixel;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !i_free;
    assign w_acc       = i_in_valid && i_free;
    assign w_is_pixel  = (i_in_data.mode == MODE_PIXEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_8BPP;
            r_width  <= CFG_W'(640);
            r_height <= CFG_W'(256);
            r_stride <= CFG_W'(640);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FORMAT: r_format <= i_cfg_data[2:0];
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_STRIDE: r_stride <= i_cfg_data;
                default:    r_format <= r_format;
            endcase
        end
    end

    always_comb begin
        w_width  = ({1'b0, r_width} > CLAMP_W'(MAX_WIDTH)) ? CLAMP_W'(MAX_WIDTH)
                                                          : {1'b0, r_width};
        w_height = ({1'b0, r_height} > CLAMP_W'(MAX_HEIGHT)) ? CLAMP_W'(MAX_HEIGHT)
                                                            : {1'b0, r_height};
        if ({1'b0, r_stride} > CLAMP_W'(STRIDE_LIMIT)) begin
            w_stride = CLAMP_W'(STRIDE_LIMIT);
        end else if (r_stride == '0) begin
            w_stride = CLAMP_W'(1);
        end else begin
            w_stride = {1'b0, r_stride};
        end

        // frame start clears the position before the transaction is handled
        w_byte_c = i_in_data.frame_start ? '0 : r_byte_in_row;
        w_pix_c  = i_in_data.frame_start ? '0 : r_pix_in_row;
        w_row_c  = i_in_data.frame_start ? '0 : r_row;

        w_fmt_ok   = (r_format <= FMT_8BPP);
        w_active   = ({1'b0, w_row_c} < w_height);
        w_per_byte = pix_per_byte(r_format[1:0]);
        w_room     = ({1'b0, w_pix_c} >= w_width) ? '0 : (w_width - {1'b0, w_pix_c});
        if (!w_fmt_ok || !w_active) begin
            w_count = '0;
        end else if (w_room >= CLAMP_W'(w_per_byte)) begin
            w_count = w_per_byte;
        end else begin
            w_count = w_room[PIXN_W-1:0];
        end

        w_byte_inc = (CNT_W + 1)'(w_byte_c) + (CNT_W + 1)'(1);

        n_byte_in_row = w_byte_c;
        n_pix_in_row  = w_pix_c;
        n_row         = w_row_c;
        if (w_is_pixel && w_active) begin
            if (w_byte_inc >= (CNT_W + 1)'(w_stride)) begin
                n_byte_in_row = '0;
                n_pix_in_row  = '0;
                n_row         = w_row_c + CNT_W'(1);
            end else begin
                n_byte_in_row = w_byte_inc[BYTE_W-1:0];
                n_pix_in_row  = w_pix_c + CNT_W'(w_count);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_in_row <= '0;
            r_pix_in_row  <= '0;
            r_row         <= '0;
        end else if (w_acc) begin
            r_byte_in_row <= n_byte_in_row;
            r_pix_in_row  <= n_pix_in_row;
            r_row         <= n_row;
        end
    end

    assign o_load         = w_acc && w_is_pixel && (w_count != '0);
    assign o_job.raw_byte = i_in_data.raw_byte;
    assign o_job.fmt      = r_format[1:0];
    assign o_job.count    = w_count;
    assign o_job.x        = w_pix_c[POS_W-1:0];
    assign o_job.y        = w_row_c[POS_W-1:0];

    assign o_pal_wr.en   = w_acc && !w_is_pixel
                         && ({1'b0, i_in_data.palette_index} < 9'(PALETTE_ENTRIES));
    assign o_pal_wr.addr = i_in_data.palette_index[PAL_AW-1:0];
    assign o_pal_wr.data = i_in_data.palette_colour;

endmodule

// ===== src/ipx_unpack.sv =====
// Pixel unpacker: issues one palette read per pixel and registers the result transaction.
module ipx_unpack (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  ipx_pkg::t_job                  i_job,
    output logic                           o_free,
    input  ipx_pkg::t_pal_wr               i_pal_wr,
    output logic                           o_ram_we,
    output logic [ipx_pkg::PAL_AW-1:0]     o_ram_waddr,
    output logic [ipx_pkg::COLOUR_W-1:0]   o_ram_wdata,
    output logic                           o_ram_re,
    output logic [ipx_pkg::PAL_AW-1:0]     o_ram_raddr,
    input  logic [ipx_pkg::COLOUR_W-1:0]   i_ram_rdata,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ipx_pkg::t_out                  o_out_data
);
    import ipx_pkg::*;

    logic [7:0]           r_byte;
    logic [1:0]           r_fmt;
    logic [PIXN_W-1:0]    r_cnt;
    logic [POS_W-1:0]     r_x;
    logic [POS_W-1:0]     r_y;

    logic [PALETTE_ENTRIES-1:0] r_pal_valid;

    logic                 r_s1_valid;
    logic [POS_W-1:0]     r_s1_x, r_s1_y;
    logic                 r_s1_last;
    logic                 r_s1_hit;

    logic                 r_o_valid;
    t_out                 r_out;

    logic                 w_s1_adv, w_s1_free, w_issue;
    logic [7:0]           w_idx;
    logic                 w_in_range;

    assign w_s1_adv   = !r_o_valid || !i_out_stall;
    assign w_s1_free  = !r_s1_valid || w_s1_adv;
    assign w_issue    = (r_cnt != '0) && w_s1_free;
    assign o_free     = (r_cnt == '0) || ((r_cnt == PIXN_W'(1)) && w_issue);
    assign w_idx      = r_byte & pix_mask(r_fmt);
    assign w_in_range = ({1'b0, w_idx} < 9'(PALETTE_ENTRIES));

    assign o_ram_we    = i_pal_wr.en;
    assign o_ram_waddr = i_pal_wr.addr;
    assign o_ram_wdata = i_pal_wr.data;
    assign o_ram_re    = w_issue;
    assign o_ram_raddr = w_idx[PAL_AW-1:0];

    // job register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_job.count;
        end else if (w_issue) begin
            r_cnt <= r_cnt - PIXN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_job.raw_byte;
            r_fmt  <= i_job.fmt;
            r_x    <= i_job.x;
            r_y    <= i_job.y;
        end else if (w_issue) begin
            r_byte <= pix_next(r_byte, r_fmt);
            r_x    <= r_x + POS_W'(1);
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_valid <= '0;
        end else if (i_pal_wr.en) begin
            r_pal_valid[i_pal_wr.addr] <= 1'b1;
        end
    end

    // read stage: RAM output is held while this stage waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_x    <= r_x;
            r_s1_y    <= r_y;
            r_s1_last <= (r_cnt == PIXN_W'(1));
            r_s1_hit  <= w_in_range && r_pal_valid[w_idx[PAL_AW-1:0]];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_valid) begin
            r_out.pixel_argb   <= r_s1_hit ? i_ram_rdata : '0;
            r_out.pixel_x      <= r_s1_x;
            r_out.pixel_y      <= r_s1_y;
            r_out.last_of_byte <= r_s1_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;

    a_load_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("job loaded while unpacker busy");

    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_adv |=> r_s1_valid && $stable(i_ram_rdata))
        else $error("palette read data lost while read stage stalled");

    a_last_tag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue && (r_cnt == PIXN_W'(1)) |=> r_s1_valid && r_s1_last)
        else $error("final pixel of byte not tagged");

    a_idle_stays : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) && !i_load |=> (r_cnt == '0))
        else $error("unpacker started without a job");

endmodule

// ===== src/indexed_pixel_palette_expander_unit.sv =====
// Indexed pixel palette expander: packed palettized bytes in, positioned ARGB32 pixels out.
// A transaction is a palette write or one raw byte. Palette writes and bytes that yield no
// pixel do not occupy the unpacker; a byte that yields pixels (up to eight at 1bpp) keeps it
// busy until each pixel has issued its one read of the 256 x 32 palette RAM, which has a single
// read port. The next byte is taken in the cycle its predecessor issues its last read. Each
// pixel passes the read stage, then the output register; an output stall can hold either.
// Configuration writes are taken at any time and apply from the next byte.
module indexed_pixel_palette_expander_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ipx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ipx_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ipx_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ipx_pkg::t_out                 o_out_data
);
    import ipx_pkg::*;

    logic                w_free, w_load;
    t_job                w_job;
    t_pal_wr             w_pal_wr;
    logic                w_ram_we, w_ram_re;
    logic [PAL_AW-1:0]   w_ram_waddr, w_ram_raddr;
    logic [COLOUR_W-1:0] w_ram_wdata, w_ram_rdata;

    ipx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_free      (w_free),
        .o_load      (w_load),
        .o_job       (w_job),
        .o_pal_wr    (w_pal_wr)
    );

    ipx_unpack u_unpack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_job       (w_job),
        .o_free      (w_free),
        .i_pal_wr    (w_pal_wr),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    ipx_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PALETTE_ENTRIES),
        .AW    (PAL_AW)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule
